// ----- hw/rtl/wavetable_note_voice_mixer_top_macros.svh -----
`ifndef WAVETABLE_NOTE_VOICE_MIXER_TOP_MACROS_SVH
`define WAVETABLE_NOTE_VOICE_MIXER_TOP_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define WTNVM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define WTNVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wtnvm_pkg.sv -----
`timescale 1ns / 1ps

package wtnvm_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [16:0]        ENV_ONE         = 17'h10000;
    localparam logic [15:0]        RELEASE_GAIN    = 16'd58982;
    localparam logic [23:0]        RELEASE_SAMPLES = 24'd100;
    localparam logic signed [17:0] SAT_MAX         = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN         = -18'sd32768;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_MIX   = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_LOOP_END      = 3'd0,
        CFG_LOOP_LENGTH   = 3'd1,
        CFG_DECAY_START   = 3'd2,
        CFG_DECAY_RATE    = 3'd3,
        CFG_TOTAL_SAMPLES = 3'd4,
        CFG_PITCH_STEP    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DISPATCH = 4'd1,
        ST_READ1    = 4'd2,
        ST_MULF     = 4'd3,
        ST_INTERP   = 4'd4,
        ST_MULE     = 4'd5,
        ST_MIX      = 4'd6,
        ST_WRAP     = 4'd7,
        ST_ENV      = 4'd8,
        ST_EMIT     = 4'd9
    } upc_t;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_WAIT_MIX = 2'd1,
        JMP_IF_PASS  = 2'd2,
        JMP_WAIT_OUT = 2'd3
    } jump_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_FRAC = 2'd1,
        MUL_ENV  = 2'd2,
        MUL_GAIN = 2'd3
    } mul_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_S0       = 3'd2,
        OP_INTERP   = 3'd3,
        OP_MIX      = 3'd4,
        OP_WRAP     = 3'd5,
        OP_ENV      = 3'd6
    } dp_op_t;

    typedef struct packed {
        jump_t  jmp;
        upc_t   target;
        logic   rd_a1;
        mul_t   mul;
        dp_op_t op;
    } ucode_t;

    typedef struct packed {
        logic [11:0] loop_end;
        logic [11:0] loop_length;
        logic [23:0] decay_start;
        logic [15:0] decay_rate;
        logic [23:0] total_samples;
        logic [18:0] pitch_step;
    } cfg_t;

    typedef struct packed {
        ucode_t uc;
        logic   load_en;
        logic   start_en;
        logic   mix_take;
    } dp_ctrl_t;

    typedef struct packed {
        logic               pass;
        logic               done;
        logic signed [15:0] res;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        w = '{jmp: JMP_NEXT, target: ST_IDLE, rd_a1: 1'b0, mul: MUL_NONE, op: OP_NONE};
        unique case (pc)
            ST_IDLE:
            begin
                w.jmp    = JMP_WAIT_MIX;
                w.target = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                w.jmp    = JMP_IF_PASS;
                w.target = ST_EMIT;
                w.op     = OP_DISPATCH;
            end
            ST_READ1:
            begin
                w.rd_a1 = 1'b1;
                w.op    = OP_S0;
            end
            ST_MULF:   w.mul = MUL_FRAC;
            ST_INTERP: w.op  = OP_INTERP;
            ST_MULE:   w.mul = MUL_ENV;
            ST_MIX:    w.op  = OP_MIX;
            ST_WRAP:
            begin
                w.mul = MUL_GAIN;
                w.op  = OP_WRAP;
            end
            ST_ENV:    w.op  = OP_ENV;
            ST_EMIT:
            begin
                w.jmp    = JMP_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_WAIT_OUT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [19:0] trunc_q16(input logic signed [35:0] p);
        logic signed [35:0] adj;
        adj = p[35] ? (p + 36'sd65535) : p;
        return 20'(adj >>> 16);
    endfunction

endpackage

// ----- hw/rtl/wtnvm_voice_dp.sv -----
`timescale 1ns / 1ps

module wtnvm_voice_dp
    import wtnvm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    input  cfg_t               cfg,
    input  logic [11:0]        table_addr,
    input  logic signed [15:0] table_value,
    input  logic signed [15:0] mix_in,
    input  logic [23:0]        start_delay,
    input  logic [27:0]        start_pos,
    input  logic [16:0]        start_env,
    output dp_stat_t           stat
);

    logic signed [15:0] mem [TABLE_DEPTH];

    logic signed [15:0] rdata_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] interp_reg;
    logic signed [35:0] prod_reg;
    logic signed [15:0] res_reg;
    logic signed [15:0] mix_in_reg;

    logic [28:0] read_pos_reg;
    logic [16:0] env_reg;
    logic [23:0] played_reg;
    logic [23:0] delay_reg;
    logic        ended_reg;
    logic        rel_reg;
    logic        dec_reg;

    logic [TABLE_AW-1:0] a1;
    logic [TABLE_AW-1:0] a0;
    logic [TABLE_AW-1:0] rd_addr;
    logic [TABLE_AW-1:0] wr_addr;
    logic signed [16:0]  diff;
    logic signed [17:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [35:0]  mul_p;
    logic [15:0]         gain;
    logic signed [19:0]  trunc_v;
    logic signed [16:0]  interp_sum;
    logic signed [17:0]  mix_sum;
    logic signed [15:0]  mix_sat;
    logic [28:0]         pos_sum;
    logic [28:0]         loop_lim;
    logic [28:0]         loop_back;
    logic                over;
    logic [23:0]         remaining;
    logic                rel_next;
    logic                dec_next;
    logic                done;
    logic [16:0]         env_start;

    assign a1      = TABLE_AW'(read_pos_reg[28:16]);
    assign a0      = a1 - {{(TABLE_AW-1){1'b0}}, 1'b1};
    assign rd_addr = ctrl.uc.rd_a1 ? a1 : a0;
    assign wr_addr = TABLE_AW'(table_addr);

    assign diff = {rdata_reg[15], rdata_reg} - {s0_reg[15], s0_reg};
    assign gain = rel_reg ? RELEASE_GAIN : cfg.decay_rate;

    always_comb
    begin
        case (ctrl.uc.mul)
            MUL_FRAC:
            begin
                mul_a = {2'b00, read_pos_reg[15:0]};
                mul_b = {diff[16], diff};
            end
            MUL_ENV:
            begin
                mul_a = {1'b0, env_reg};
                mul_b = {{2{interp_reg[15]}}, interp_reg};
            end
            MUL_GAIN:
            begin
                mul_a = {1'b0, env_reg};
                mul_b = {2'b00, gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign trunc_v    = trunc_q16(prod_reg);
    assign interp_sum = {s0_reg[15], s0_reg} + trunc_v[16:0];
    assign mix_sum    = {{2{mix_in_reg[15]}}, mix_in_reg} + trunc_v[17:0];

    always_comb
    begin
        if (mix_sum > SAT_MAX)
            mix_sat = SAT_MAX[15:0];
        else if (mix_sum < SAT_MIN)
            mix_sat = SAT_MIN[15:0];
        else
            mix_sat = mix_sum[15:0];
    end

    assign pos_sum   = read_pos_reg + {10'd0, cfg.pitch_step};
    assign loop_lim  = {1'b0, cfg.loop_end, 16'h0000};
    assign loop_back = read_pos_reg - {1'b0, cfg.loop_length, 16'h0000};
    assign over      = read_pos_reg > loop_lim;

    assign remaining = cfg.total_samples - played_reg;
    assign rel_next  = remaining < RELEASE_SAMPLES;
    assign dec_next  = played_reg > cfg.decay_start;
    assign done      = played_reg >= cfg.total_samples;
    assign env_start = (start_env > ENV_ONE) ? ENV_ONE : start_env;

    assign stat.pass = (delay_reg != 24'd0) || done;
    assign stat.done = done;
    assign stat.res  = res_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
            mem[wr_addr] <= table_value;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mix_take)
            mix_in_reg <= mix_in;
        if (ctrl.uc.mul != MUL_NONE)
            prod_reg <= mul_p;
        case (ctrl.uc.op)
            OP_DISPATCH: res_reg    <= mix_in_reg;
            OP_S0:       s0_reg     <= rdata_reg;
            OP_INTERP:   interp_reg <= interp_sum[15:0];
            OP_MIX:      res_reg    <= mix_sat;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pos_reg <= '0;
            env_reg      <= '0;
            played_reg   <= '0;
            delay_reg    <= '0;
            ended_reg    <= 1'b0;
            rel_reg      <= 1'b0;
            dec_reg      <= 1'b0;
        end
        else if (ctrl.start_en)
        begin
            delay_reg    <= start_delay;
            read_pos_reg <= {1'b0, start_pos};
            env_reg      <= env_start;
            played_reg   <= '0;
        end
        else
        begin
            case (ctrl.uc.op)
                OP_DISPATCH:
                begin
                    if (delay_reg != 24'd0)
                        delay_reg <= delay_reg - 24'd1;
                end
                OP_MIX:
                begin
                    read_pos_reg <= pos_sum;
                    ended_reg    <= 1'b0;
                    rel_reg      <= rel_next;
                    dec_reg      <= dec_next;
                end
                OP_WRAP:
                begin
                    if (over)
                    begin
                        if (cfg.loop_length == 12'd0)
                        begin
                            ended_reg  <= 1'b1;
                            played_reg <= cfg.total_samples;
                        end
                        else
                        begin
                            read_pos_reg <= loop_back;
                        end
                    end
                end
                OP_ENV:
                begin
                    if (!ended_reg)
                    begin
                        if (rel_reg || dec_reg)
                            env_reg <= prod_reg[32:16];
                        played_reg <= played_reg + 24'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/wavetable_note_voice_mixer_top.sv -----
`timescale 1ns / 1ps
// Load and start transfers complete in the cycle they are accepted; no result.
// Mix while the note sounds: DISPATCH, READ1, MULF, INTERP, MULE, MIX, WRAP, ENV, EMIT.
// Mix during the start delay or after the note: DISPATCH branches straight to EMIT.
// EMIT registers the result; the microcode step counter shares one 18x18 multiplier.
// Reset clears the sequencer, out_valid, config and voice state; table and output data stay.
`include "wavetable_note_voice_mixer_top_macros.svh"

module wavetable_note_voice_mixer_top
    import wtnvm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [11:0]        table_addr,
    input  logic signed [15:0] table_value,
    input  logic signed [15:0] mix_in,
    input  logic [23:0]        start_delay,
    input  logic [27:0]        start_pos,
    input  logic [16:0]        start_env,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mix_out,
    output logic               note_done
);

    cfg_t     cfg_reg;
    upc_t     upc_reg;
    upc_t     upc_next;
    upc_t     upc_inc;
    ucode_t   uc;
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] mix_out_reg;
    logic               note_done_reg;
    logic               in_xfer;
    logic               mix_xfer;
    logic               out_free;
    logic               emit_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_end      <= '0;
            cfg_reg.loop_length   <= '0;
            cfg_reg.decay_start   <= '0;
            cfg_reg.decay_rate    <= 16'hFFFF;
            cfg_reg.total_samples <= '0;
            cfg_reg.pitch_step    <= 19'h10000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOOP_END:      cfg_reg.loop_end      <= cfg_data[11:0];
                CFG_LOOP_LENGTH:   cfg_reg.loop_length   <= cfg_data[11:0];
                CFG_DECAY_START:   cfg_reg.decay_start   <= cfg_data;
                CFG_DECAY_RATE:    cfg_reg.decay_rate    <= cfg_data[15:0];
                CFG_TOTAL_SAMPLES: cfg_reg.total_samples <= cfg_data;
                CFG_PITCH_STEP:    cfg_reg.pitch_step    <= cfg_data[18:0];
                default:
                begin
                end
            endcase
        end
    end

    assign uc        = ucode_rom(upc_reg);
    assign in_stall  = (upc_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign mix_xfer  = in_xfer && (cmd == CMD_MIX);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (upc_reg == ST_EMIT) && out_free;
    assign upc_inc   = upc_t'(upc_reg + 4'd1);

    always_comb
    begin
        unique case (uc.jmp)
            JMP_NEXT:     upc_next = upc_inc;
            JMP_WAIT_MIX: upc_next = mix_xfer ? uc.target : upc_reg;
            JMP_IF_PASS:  upc_next = stat.pass ? uc.target : upc_inc;
            JMP_WAIT_OUT: upc_next = out_free ? uc.target : upc_reg;
            default:      upc_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.uc       = uc;
        ctrl.load_en  = in_xfer && (cmd == CMD_LOAD);
        ctrl.start_en = in_xfer && (cmd == CMD_START);
        ctrl.mix_take = mix_xfer;
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            mix_out_reg   <= stat.res;
            note_done_reg <= stat.done;
        end
    end

    wtnvm_voice_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .table_addr  (table_addr),
        .table_value (table_value),
        .mix_in      (mix_in),
        .start_delay (start_delay),
        .start_pos   (start_pos),
        .start_env   (start_env),
        .stat        (stat)
    );

    assign out_valid = out_valid_reg;
    assign mix_out   = mix_out_reg;
    assign note_done = note_done_reg;

    `WTNVM_ASSERT_NEXT(a_mix_starts, mix_xfer, upc_reg == ST_DISPATCH, "mix transfer did not start program")
    `WTNVM_ASSERT_NEXT(a_emit_lands, emit_fire, out_valid_reg && upc_reg == ST_IDLE, "emit lost result")
    `WTNVM_ASSERT_NEXT(a_pass_skip, upc_reg == ST_DISPATCH && stat.pass, upc_reg == ST_EMIT, "pass branch missed")
    `WTNVM_ASSERT_SAME(a_busy_no_load, upc_reg != ST_IDLE, !ctrl.load_en && !ctrl.start_en, "state write while busy")

endmodule
